[rtl/ssir_pkg.sv]
// shared types and constants for the sorted set insert/remove unit
// no dependencies; used by ssir_cell and sorted_set_insert_remove_unit
package ssir_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 3;
    localparam int ENTRY_CNT_W  = 7;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_RES
    } t_state;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic remove;
    } t_cell_ctl;

endpackage

[rtl/ssir_cell.sv]
// one slot of the ordered store: holds one entry, compares it against the
// request value and shifts with its neighbours; depends on ssir_pkg
module ssir_cell (
    input  logic                         i_clk,
    input  ssir_pkg::t_cell_ctl          i_ctl,
    input  logic [ssir_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_occ,
    input  logic                         i_left_lt,
    input  logic [ssir_pkg::VALUE_W-1:0] i_left_entry,
    input  logic [ssir_pkg::VALUE_W-1:0] i_right_entry,
    output logic [ssir_pkg::VALUE_W-1:0] o_entry,
    output logic                         o_lt,
    output logic                         o_eq
);
    import ssir_pkg::*;

    logic [VALUE_W-1:0] r_entry;
    logic [VALUE_W-1:0] n_entry;
    logic               r_lt;
    logic               r_eq;

    // compare phase: flags only for occupied slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= i_occ && ($signed(r_entry) < $signed(i_value));
            r_eq <= i_occ && (r_entry == i_value);
        end
        if (i_ctl.upd_en) begin
            r_entry <= n_entry;
        end
    end

    // insert: slots below the insertion point keep, the boundary slot takes
    // the value, higher slots take the left neighbour; remove pulls from the right
    always_comb begin
        if (r_lt) begin
            n_entry = r_entry;
        end else if (i_ctl.remove) begin
            n_entry = i_right_entry;
        end else if (i_left_lt) begin
            n_entry = i_value;
        end else begin
            n_entry = i_left_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

[rtl/sorted_set_insert_remove_unit.sv]
// top level of the sorted set insert/remove unit: sequencer, count and
// result register around a chain of ssir_cell; depends on ssir_pkg, ssir_cell
//
// usage
//   request channel  : i_in_valid / o_in_stall carrying i_op (0 insert,
//                      1 remove) and the signed i_value
//   result channel   : o_out_valid / i_out_stall carrying o_status,
//                      o_entry_count, o_is_empty, o_smallest, o_largest
//   a request is taken on a rising edge with valid high and stall low
//   each request passes four steps: accept, compare in every cell, update
//   (shift of the chain), result gather; the result register is loaded in
//   the gather step, and no new request is taken until that step is done
//   the one-request-at-a-time sequencer sets this: all cells compare in
//   the same cycle and shift in the next, then the smallest and
//   largest entries are picked from the settled chain
//   the result sits in an output register, so a following request is
//   accepted while an earlier result still waits; if the receiver stalls,
//   the gather step holds until the register frees and the chain holds too
//   synchronous active-low reset empties the store (count to zero) and
//   clears both handshakes; entry contents need no reset, slots at or
//   above the count are never looked at
//   entry_count is the count on 7 bits and wraps for capacities above 127
module sorted_set_insert_remove_unit #(
    parameter int CAPACITY = ssir_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [ssir_pkg::VALUE_W-1:0]     i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ssir_pkg::STATUS_W-1:0]    o_status,
    output logic [ssir_pkg::ENTRY_CNT_W-1:0] o_entry_count,
    output logic                             o_is_empty,
    output logic [ssir_pkg::VALUE_W-1:0]     o_smallest,
    output logic [ssir_pkg::VALUE_W-1:0]     o_largest
);
    import ssir_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer
    t_state r_state;
    t_state n_state;

    // request held while it is worked on
    logic               r_op;
    logic [VALUE_W-1:0] r_value;

    // store occupancy
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // status of the request, settled in the update cycle
    logic [STATUS_W-1:0] r_req_status;
    logic [STATUS_W-1:0] n_req_status;

    // output register
    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [ENTRY_CNT_W-1:0] r_entry_count;
    logic                   r_is_empty;
    logic [VALUE_W-1:0]     r_smallest;
    logic [VALUE_W-1:0]     r_largest;

    // chain wiring
    logic [VALUE_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_last;

    logic      w_accept;
    logic      w_hit;
    logic      w_full;
    logic      w_apply;
    logic      w_out_free;
    logic      w_load;
    t_cell_ctl w_ctl;
    logic [VALUE_W-1:0] w_largest;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_hit      = |w_eq;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // the request changes the store only for a new value with room,
    // or for a remove that found its value
    assign w_apply = (r_op == OP_REMOVE) ? w_hit : (!w_hit && !w_full);

    // per-slot occupancy and last-entry flags from the count
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_occ[k]  = (CW'(k) < r_count);
            w_last[k] = (CW'(k + 1) == r_count);
        end
    end

    // largest entry: and-or over the slots, only the last occupied one passes
    always_comb begin
        w_largest = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_largest = w_largest | (w_entry[k] & {VALUE_W{w_last[k]}});
        end
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic               w_left_lt;
        logic [VALUE_W-1:0] w_left_entry;
        logic [VALUE_W-1:0] w_right_entry;

        if (g == 0) begin : g_first
            // nothing below the first slot, so it is always a boundary
            assign w_left_lt    = 1'b1;
            assign w_left_entry = r_value;
        end else begin : g_mid
            assign w_left_lt    = w_lt[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right_entry = w_entry[g];
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        ssir_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_value       (r_value),
            .i_occ         (w_occ[g]),
            .i_left_lt     (w_left_lt),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[g]),
            .o_lt          (w_lt[g]),
            .o_eq          (w_eq[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_UPD;
            S_UPD: n_state = S_RES;
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs; no request is taken while reset is held
    always_comb begin
        o_in_stall   = 1'b1;
        w_ctl.cmp_en = 1'b0;
        w_ctl.upd_en = 1'b0;
        w_ctl.remove = r_op;
        w_load       = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = !i_rst_n;
            S_CMP:  w_ctl.cmp_en = 1'b1;
            S_UPD:  w_ctl.upd_en = w_apply;
            S_RES:  w_load = w_out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    // status and count of the request
    always_comb begin
        n_count = r_count;
        if (r_op == OP_REMOVE) begin
            if (w_hit) begin
                n_req_status = ST_REMOVED;
                n_count      = r_count - CW'(1);
            end else begin
                n_req_status = ST_NOT_FOUND;
            end
        end else begin
            if (w_hit) begin
                n_req_status = ST_DUPLICATE;
            end else if (w_full) begin
                n_req_status = ST_FULL;
            end else begin
                n_req_status = ST_INSERTED;
                n_count      = r_count + CW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
        if (r_state == S_UPD) begin
            r_req_status <= n_req_status;
        end
        if (w_load) begin
            r_status      <= r_req_status;
            r_entry_count <= ENTRY_CNT_W'(r_count);
            r_is_empty    <= (r_count == '0);
            r_smallest    <= (r_count == '0) ? '0 : w_entry[0];
            r_largest     <= w_largest;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_smallest    = r_smallest;
    assign o_largest     = r_largest;

endmodule
